/* rtl/mrpt_pkg.sv */
`timescale 1ns / 1ps

package mrpt_pkg;

   // Default operand width of the test.
   localparam int VALUE_BITS_DEFAULT = 32;

   // Width of the witness span register and its value after reset.
   localparam int SPAN_BITS  = 5;
   localparam int SPAN_RESET = 5;

   // The first witness base. The witness counter must hold the last base plus one.
   localparam int FIRST_WITNESS = 2;
   localparam int WITNESS_BITS  = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SPLIT,
      ST_WIT,
      ST_POW,
      ST_WAIT_ACC,
      ST_WAIT_SQ,
      ST_SQR,
      ST_WAIT_Z,
      ST_FINISH
   } mrpt_state_type;

endpackage

/* rtl/miller_rabin_prime_test.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                              Transfer when
// request   in         req_valid, req_stall, req_candidate  req_valid && !req_stall
// response  out        rsp_valid, rsp_stall, rsp_prime      rsp_valid && !rsp_stall
// csr       in         csr_wr_en, csr_wr_data             csr_wr_en
//
// One candidate is tested at a time; req_stall stays high from its transfer until the
// sequencer is back in idle. Each modular product runs on the shared multiplier and a
// witness needs at most about 2*(VALUE_BITS-1) of them; the reset span tries six bases.
// Values below three and even values go from the preparation state straight to the
// finish state. Reset idles the sequencer, drops rsp_valid and sets the span to 5. A
// stalled answer waits in the output register; the next candidate may run meanwhile and
// waits in the finish state until that register is free.
module miller_rabin_prime_test #(
   parameter int VALUE_BITS = mrpt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_candidate,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_prime,
   input  logic                           csr_wr_en,
   input  logic [mrpt_pkg::SPAN_BITS-1:0] csr_wr_data
);

   import mrpt_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   mrpt_state_type state_ff, state_in;

   logic [SPAN_BITS-1:0]    span_ff;
   logic [VALUE_BITS-1:0]   n_ff, n_in;
   logic [VALUE_BITS-1:0]   nm1_ff, nm1_in;
   logic [VALUE_BITS-1:0]   d_ff, d_in;
   logic [CNT_BITS-1:0]     s_ff, s_in;
   logic [CNT_BITS-1:0]     left_ff, left_in;
   logic [WITNESS_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic [VALUE_BITS-1:0]   sq_ff, sq_in;
   logic [VALUE_BITS-1:0]   exp_ff, exp_in;
   logic [VALUE_BITS-1:0]   y_ff, y_in;
   logic                    res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_prime_ff, rsp_prime_in;

   logic [VALUE_BITS-1:0]   cand_low;
   logic [VALUE_BITS-1:0]   cand_mag;
   logic [WITNESS_BITS-1:0] last_base;
   logic [VALUE_BITS-1:0]   base_plus_two;
   logic                    slot_free;

   logic                    mul_start;
   logic [VALUE_BITS-1:0]   mul_x;
   logic [VALUE_BITS-1:0]   mul_y;
   logic                    mul_done;
   logic [VALUE_BITS-1:0]   mul_result;

   mrpt_mulmod #(
      .VALUE_BITS (VALUE_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .x      (mul_x),
      .y      (mul_y),
      .n      (n_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   // The low VALUE_BITS bits are read as a signed value; its magnitude fits unsigned,
   // including the most negative value.
   assign cand_low = req_candidate[VALUE_BITS-1:0];
   assign cand_mag = cand_low[VALUE_BITS-1] ? (~cand_low + VALUE_BITS'(1)) : cand_low;

   assign last_base     = WITNESS_BITS'(FIRST_WITNESS) + {1'b0, span_ff};
   // A base is usable only while it does not exceed n-2.
   assign base_plus_two = {{(VALUE_BITS-WITNESS_BITS){1'b0}}, a_ff}
                        + VALUE_BITS'(FIRST_WITNESS);

   // The output register can take a new answer if it is empty or being drained now.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      nm1_in    = nm1_ff;
      d_in      = d_ff;
      s_in      = s_ff;
      left_in   = left_ff;
      a_in      = a_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      exp_in    = exp_ff;
      y_in      = y_ff;
      res_in    = res_ff;
      mul_start = 1'b0;
      mul_x     = acc_ff;
      mul_y     = sq_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = cand_mag;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // Values below three are prime only when equal to two; even values are composite.
            if (n_ff < VALUE_BITS'(3)) begin
               res_in   = (n_ff == VALUE_BITS'(2));
               state_in = ST_FINISH;
            end else if (!n_ff[0]) begin
               res_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               nm1_in   = n_ff - VALUE_BITS'(1);
               d_in     = n_ff - VALUE_BITS'(1);
               s_in     = '0;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            // Strip the factors of two from n-1, one per cycle.
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[VALUE_BITS-1:1]};
               s_in = s_ff + CNT_BITS'(1);
            end else begin
               a_in     = WITNESS_BITS'(FIRST_WITNESS);
               state_in = ST_WIT;
            end
         end
         ST_WIT: begin
            if ((a_ff <= last_base) && (base_plus_two <= n_ff)) begin
               acc_in   = VALUE_BITS'(1);
               sq_in    = {{(VALUE_BITS-WITNESS_BITS){1'b0}}, a_ff};
               exp_in   = d_ff;
               y_in     = '0;
               left_in  = s_ff;
               state_in = ST_POW;
            end else begin
               res_in   = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_POW: begin
            // Square-and-multiply over the exponent, least significant bit first.
            if (exp_ff == '0) begin
               state_in = ST_SQR;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_x     = acc_ff;
               mul_y     = sq_ff;
               state_in  = ST_WAIT_ACC;
            end else begin
               mul_start = 1'b1;
               mul_x     = sq_ff;
               mul_y     = sq_ff;
               state_in  = ST_WAIT_SQ;
            end
         end
         ST_WAIT_ACC: begin
            if (mul_done) begin
               acc_in = mul_result;
               if (exp_ff[VALUE_BITS-1:1] == '0) begin
                  // No exponent bits remain, so the base needs no further squaring.
                  exp_in   = '0;
                  state_in = ST_POW;
               end else begin
                  mul_start = 1'b1;
                  mul_x     = sq_ff;
                  mul_y     = sq_ff;
                  state_in  = ST_WAIT_SQ;
               end
            end
         end
         ST_WAIT_SQ: begin
            if (mul_done) begin
               sq_in    = mul_result;
               exp_in   = {1'b0, exp_ff[VALUE_BITS-1:1]};
               state_in = ST_POW;
            end
         end
         ST_SQR: begin
            if (left_ff == '0) begin
               // The last square must be one, otherwise the witness proves compositeness.
               if (y_ff != VALUE_BITS'(1)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  a_in     = a_ff + WITNESS_BITS'(1);
                  state_in = ST_WIT;
               end
            end else begin
               mul_start = 1'b1;
               mul_x     = acc_ff;
               mul_y     = acc_ff;
               state_in  = ST_WAIT_Z;
            end
         end
         ST_WAIT_Z: begin
            if (mul_done) begin
               // A square of one from a root other than 1 or n-1 is a nontrivial root.
               if ((mul_result == VALUE_BITS'(1)) && (acc_ff != VALUE_BITS'(1))
                   && (acc_ff != nm1_ff)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = mul_result;
                  y_in     = mul_result;
                  left_in  = left_ff - CNT_BITS'(1);
                  state_in = ST_SQR;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         span_ff      <= SPAN_BITS'(SPAN_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            span_ff <= csr_wr_data;
         end
      end
      n_ff         <= n_in;
      nm1_ff       <= nm1_in;
      d_ff         <= d_in;
      s_ff         <= s_in;
      left_ff      <= left_in;
      a_ff         <= a_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      exp_ff       <= exp_in;
      y_ff         <= y_in;
      res_ff       <= res_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = rsp_prime_ff;

   // The multiplier reports a product only while the sequencer waits for one.
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_WAIT_ACC || state_ff == ST_WAIT_SQ
                    || state_ff == ST_WAIT_Z))
      else $error("modular product arrived outside a wait state");

   // Operands handed to the multiplier are always reduced below the modulus.
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW || state_ff == ST_SQR) |-> (acc_ff < n_ff && sq_ff < n_ff))
      else $error("modular operand not below the modulus");

   // Only odd moduli reach the witness rounds.
   a_witness_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIT) |-> n_ff[0])
      else $error("even modulus entered the witness loop");

   // A new answer appears only out of the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised without a finished test");

endmodule

/* rtl/mrpt_mulmod.sv */
`timescale 1ns / 1ps

// Shift-and-add modular multiplier: x * y mod n, one bit of y per cycle, MSB first.
// Operands must be below n. The modulus must stay stable while the unit is busy.
module mrpt_mulmod #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] x,
   input  logic [VALUE_BITS-1:0] y,
   input  logic [VALUE_BITS-1:0] n,
   output logic                  done,
   output logic [VALUE_BITS-1:0] result
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] x_ff, x_in;
   logic [VALUE_BITS-1:0] y_ff, y_in;

   logic [VALUE_BITS+1:0] sum;
   logic [VALUE_BITS+1:0] n1;
   logic [VALUE_BITS+1:0] n2;
   logic [VALUE_BITS+1:0] reduced;

   // The running sum stays below n, so twice it plus x stays below 3n.
   assign sum = {1'b0, acc_ff, 1'b0}
              + (y_ff[VALUE_BITS-1] ? {2'b00, x_ff} : '0);
   assign n1  = {2'b00, n};
   assign n2  = {1'b0, n, 1'b0};

   always_comb begin
      if (sum >= n2) begin
         reduced = sum - n2;
      end else if (sum >= n1) begin
         reduced = sum - n1;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
      end else if (busy_ff) begin
         acc_in = reduced[VALUE_BITS-1:0];
         y_in   = {y_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

/* tb/sv/tb_miller_rabin_prime_test.sv */
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test;

   import mrpt_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;

   // One expected answer, kept with the candidate that caused it so that a
   // mismatch report can say which value went wrong.
   typedef struct {
      logic signed [31:0] candidate;
      logic               prime;
   } prime_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_candidate = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_prime;
   logic                  csr_wr_en = 1'b0;
   logic [SPAN_BITS-1:0]  csr_wr_data = '0;

   // Candidates waiting to be offered, and the answers that the accepted
   // candidates are owed, oldest first.
   logic signed [31:0]    candidate_queue[$];
   prime_verdict_type     verdict_queue[$];

   // The witness span as the block holds it; it only changes while the block is idle.
   logic [SPAN_BITS-1:0]  span_setting = SPAN_BITS'(SPAN_RESET);

   int                    sender_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    error_count = 0;
   longint                cycle_count = 0;
   longint                cycle_limit = 20000;

   miller_rabin_prime_test #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prime    (rsp_prime),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Exact modular product: both operands are below 2^32, so the 64-bit product
   // never wraps.
   function automatic longint unsigned mod_product(longint unsigned x, longint unsigned y,
                                                   longint unsigned modulus);
      return (x * y) % modulus;
   endfunction

   // Right-to-left square-and-multiply.
   function automatic longint unsigned mod_power(longint unsigned base,
                                                 longint unsigned exponent,
                                                 longint unsigned modulus);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned e;
      acc = 1 % modulus;
      sq  = base % modulus;
      e   = exponent;
      while (e > 0) begin
         if (e[0]) acc = mod_product(acc, sq, modulus);
         sq = mod_product(sq, sq, modulus);
         e  = e >> 1;
      end
      return acc;
   endfunction

   // The block looks at the low VALUE_BITS bits only, sign-extends them and
   // tests the magnitude. The most negative value has a magnitude one past the
   // positive range, and the 64-bit arithmetic keeps it exact.
   function automatic longint unsigned candidate_magnitude(logic signed [31:0] cand);
      longint unsigned mask;
      longint unsigned sign;
      longint unsigned v;
      mask = (64'd1 << VALUE_BITS) - 1;
      sign = 64'd1 << (VALUE_BITS - 1);
      v = {32'd0, cand[31:0]} & mask;
      if ((v & sign) != 0) return (~v + 1) & mask;
      return v;
   endfunction

   // Miller-Rabin over the bases 2 .. 2+span, never above n-2. A square that lands
   // on 1 from anything but 1 or n-1 proves the value composite, and so does a
   // last square other than 1.
   function automatic logic miller_rabin_verdict(logic signed [31:0] cand,
                                                 logic [SPAN_BITS-1:0] span);
      longint unsigned n;
      longint unsigned d;
      longint unsigned s;
      longint unsigned a;
      longint unsigned last;
      longint unsigned i;
      longint unsigned z;
      longint unsigned y;
      logic            prime;
      n = candidate_magnitude(cand);
      if (n < 3) return n == 2;
      if (n[0] == 1'b0) return 1'b0;
      d = n - 1;
      s = 0;
      while (d[0] == 1'b0) begin
         d = d >> 1;
         s++;
      end
      prime = 1'b1;
      last  = FIRST_WITNESS + span;
      for (a = FIRST_WITNESS; prime && a <= last && a <= n - 2; a++) begin
         z = mod_power(a, d, n);
         y = 0;
         for (i = 0; i < s && prime; i++) begin
            y = mod_product(z, z, n);
            if (y == 1 && z != 1 && z != n - 1) prime = 1'b0;
            z = y;
         end
         if (y != 1) prime = 1'b0;
      end
      return prime;
   endfunction

   // A pessimistic cycle count for one candidate: every base that can run, each
   // with a full-width exponent plus the squaring chain, each product on the
   // shared multiplier, with slack for handshake gaps on either side.
   function automatic longint item_cycle_bound(logic signed [31:0] cand);
      longint unsigned n;
      longint          bases;
      n = candidate_magnitude(cand);
      bases = span_setting + 1;
      if (n < 4) bases = 0;
      else if (n - 3 < bases) bases = n - 3;
      return 200 + bases * (3 * VALUE_BITS + 8) * (VALUE_BITS + 8);
   endfunction

   task automatic queue_candidate(input logic signed [31:0] cand);
      candidate_queue.insert(candidate_queue.size(), cand);
      cycle_limit += 4 * item_cycle_bound(cand);
   endtask

   // Most random candidates are small so the run stays short; a quarter are of
   // medium size and a few use the full width, which also toggles every input bit.
   function automatic logic signed [31:0] random_candidate();
      int                 pick;
      logic signed [31:0] value;
      pick = $urandom_range(99);
      if (pick < 60) value = $urandom_range(4095);
      else if (pick < 85) value = $urandom_range(1 << 20);
      else return $urandom;
      if ($urandom_range(1) == 1) value = -value;
      return value;
   endfunction

   // Driver. A new candidate is only put up once the previous one has been
   // transferred, and the payload is held for as long as the block stalls.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (candidate_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_candidate <= candidate_queue[0];
            candidate_queue.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiving side stalls the answer channel at random.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor. Each accepted candidate gets its expected answer appended, and
   // each answer transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      prime_verdict_type expected;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected.candidate = req_candidate;
            expected.prime     = miller_rabin_verdict(req_candidate, span_setting);
            verdict_queue.insert(verdict_queue.size(), expected);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: answer transfer with nothing expected, prime %0d",
                        $time, rsp_prime);
               error_count++;
            end else begin
               expected = verdict_queue[0];
               verdict_queue.delete(0);
               if (rsp_prime !== expected.prime) begin
                  $display("%0t: candidate %0d: prime expected %0d, actual %0d",
                           $time, expected.candidate, expected.prime, rsp_prime);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog. The limit grows with every candidate that is queued.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Returns once every candidate has been transferred and answered. The check
   // is made on the falling edge, clear of the updates at the rising edge.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (candidate_queue.size() != 0 || req_valid || verdict_queue.size() != 0);
   endtask

   initial begin
      int phase;
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Five phases. The first runs with the span from reset and no idling on either
      // side; the others write the span (the lowest value, the top of the 5-bit field,
      // the value 29, then a random one) and step through the idling patterns.
      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_until_drained();
            @(posedge clock);
            csr_wr_en   <= 1'b1;
            case (phase)
               1: span_setting = SPAN_BITS'(0);
               2: span_setting = SPAN_BITS'(31);
               3: span_setting = SPAN_BITS'(29);
               default: span_setting = SPAN_BITS'($urandom_range(31));
            endcase
            csr_wr_data <= span_setting;
            @(posedge clock);
            csr_wr_en   <= 1'b0;
         end

         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 66;
            end
            2: begin
               sender_idle_pct = 66;
               recv_stall_pct  = 0;
            end
            default: begin
               sender_idle_pct = 31;
               recv_stall_pct  = 31;
            end
         endcase

         case (phase)
            0: begin
               // Zero, one and two of either sign, three with no base left to try,
               // small primes and composites, a Carmichael number, strong
               // pseudoprimes to the first bases, the largest prime in range of
               // either sign, and the most negative value.
               queue_candidate(0);
               queue_candidate(1);
               queue_candidate(-1);
               queue_candidate(2);
               queue_candidate(-2);
               queue_candidate(3);
               queue_candidate(-3);
               queue_candidate(4);
               queue_candidate(5);
               queue_candidate(9);
               queue_candidate(561);
               queue_candidate(2047);
               queue_candidate(1373653);
               queue_candidate(25326001);
               queue_candidate(65537);
               queue_candidate(-7919);
               queue_candidate(2147483646);
               queue_candidate(2147483647);
               queue_candidate(-2147483647);
               queue_candidate(32'h8000_0000);
            end
            1: begin
               // With base 2 alone the strong pseudoprime slips through.
               queue_candidate(2047);
               queue_candidate(3);
            end
            2: begin
               // The widest span on the largest prime, and a value whose n-2 is
               // exactly the last base.
               queue_candidate(2147483647);
               queue_candidate(35);
            end
            default: begin
            end
         endcase

         for (k = 0; k < 16; k++) queue_candidate(random_candidate());
      end

      wait_until_drained();
      // Leave room for a stray answer to show up before the verdict.
      repeat (2000) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mrpt_pkg.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_prime_test.sv
tb/sv/tb_miller_rabin_prime_test.sv
